// File: sv/rdq_pkg.sv
package rdq_pkg;

  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_VALUE_BITS = 32;

  localparam int OP_W     = 3;
  localparam int FIELD_W  = 32;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_REVERSE    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd2;

  typedef struct packed {
    logic exec;
    logic capture;
  } rdq_cmd_t;

endpackage

// File: sv/rdq_ifs.sv
interface rdq_req_if
  import rdq_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic signed [FIELD_W-1:0] push_value;

  modport source (output valid, op, push_value, input ready);
  modport sink (input valid, op, push_value, output ready);
endinterface

interface rdq_rsp_if
  import rdq_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] front_value;
  logic signed [FIELD_W-1:0] back_value;
  logic [COUNT_W-1:0]        item_count;
  logic [STATUS_W-1:0]       status;

  modport source (output valid, front_value, back_value, item_count, status, input ready);
  modport sink (input valid, front_value, back_value, item_count, status, output ready);
endinterface

// File: sv/rdq_ctrl.sv
module rdq_ctrl
  import rdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  logic     rsp_ready,
  output logic     req_ready,
  output logic     rsp_valid,
  output rdq_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_OUT
  } state_t;

  state_t state;
  logic   capture;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      req_ready <= 1'b1;
      rsp_valid <= 1'b0;
      capture   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid && req_ready) begin
            state     <= S_READ;
            req_ready <= 1'b0;
            capture   <= 1'b1;
          end
        end
        S_READ: begin
          state     <= S_OUT;
          capture   <= 1'b0;
          rsp_valid <= 1'b1;
        end
        S_OUT: begin
          if (rsp_ready) begin
            state     <= S_IDLE;
            rsp_valid <= 1'b0;
            req_ready <= 1'b1;
          end
        end
        default: begin
          state     <= S_IDLE;
          req_ready <= 1'b1;
          rsp_valid <= 1'b0;
          capture   <= 1'b0;
        end
      endcase
    end
  end

  assign cmd.exec    = req_valid && req_ready;
  assign cmd.capture = capture;

endmodule

// File: sv/rdq_datapath.sv
module rdq_datapath
  import rdq_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  rdq_cmd_t                   cmd,
  input  logic [OP_W-1:0]            op,
  input  logic signed [FIELD_W-1:0]  push_value,
  output logic signed [FIELD_W-1:0]  front_value,
  output logic signed [FIELD_W-1:0]  back_value,
  output logic [COUNT_W-1:0]         item_count,
  output logic [STATUS_W-1:0]        status
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

  logic [VALUE_BITS-1:0] mem [CAPACITY];

  logic [IW-1:0]  low;
  logic [IW-1:0]  high;
  logic [CW-1:0]  occ;
  logic           rev;
  logic [STATUS_W-1:0] status_r;

  logic signed [VALUE_BITS-1:0] low_rd;
  logic signed [VALUE_BITS-1:0] high_rd;

  logic [IW-1:0] low_inc, low_dec, high_inc, high_dec;
  logic          is_push, is_pop, at_low_push, at_low_pop;
  logic          full, empty;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic signed [VALUE_BITS-1:0] push_v;
  logic signed [VALUE_BITS-1:0] front_sel, back_sel;

  assign low_inc  = (low == LAST_IDX) ? '0 : low + 1'b1;
  assign low_dec  = (low == '0) ? LAST_IDX : low - 1'b1;
  assign high_inc = (high == LAST_IDX) ? '0 : high + 1'b1;
  assign high_dec = (high == '0) ? LAST_IDX : high - 1'b1;

  assign is_push     = (op == OP_PUSH_FRONT) || (op == OP_PUSH_BACK);
  assign is_pop      = (op == OP_POP_FRONT) || (op == OP_POP_BACK);
  assign at_low_push = (op == OP_PUSH_FRONT) == !rev;
  assign at_low_pop  = (op == OP_POP_FRONT) == !rev;
  assign full        = (occ == FULL_CNT);
  assign empty       = (occ == '0);

  assign push_v  = VALUE_BITS'(push_value);
  assign wr_en   = cmd.exec && is_push && !full;
  assign wr_addr = at_low_push ? low_dec : high;

  always_ff @(posedge clk) begin
    if (rst) begin
      low  <= '0;
      high <= '0;
      occ  <= '0;
      rev  <= 1'b0;
    end else if (cmd.exec) begin
      if (is_push && !full) begin
        if (at_low_push) begin
          low <= low_dec;
        end else begin
          high <= high_inc;
        end
        occ <= occ + 1'b1;
      end else if (is_pop && !empty) begin
        if (at_low_pop) begin
          low <= low_inc;
        end else begin
          high <= high_dec;
        end
        occ <= occ - 1'b1;
      end else if (op == OP_REVERSE) begin
        rev <= !rev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (is_push && full) begin
        status_r <= ST_PUSH_FULL;
      end else if (is_pop && empty) begin
        status_r <= ST_POP_EMPTY;
      end else begin
        status_r <= ST_OK;
      end
    end
  end

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= push_v;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      low_rd  <= mem[low];
      high_rd <= mem[high_dec];
    end
  end

  assign front_sel = rev ? high_rd : low_rd;
  assign back_sel  = rev ? low_rd : high_rd;

  assign front_value = empty ? '1 : FIELD_W'(front_sel);
  assign back_value  = empty ? '1 : FIELD_W'(back_sel);
  assign item_count  = COUNT_W'(occ);
  assign status      = status_r;

endmodule

// File: sv/reversible_deque.sv
// reversible double-ended queue on a ring store
// req channel: one beat is one operation (op, push_value); op codes are
//   push front, push back, pop front, pop back and reverse order
// rsp channel: one beat per request beat with the logical front and back
//   values (-1 when empty), the item count and a status code
//   (ok, pop on empty ignored, push on full dropped)
// reverse only flips which physical end of the ring is the front; no data moves
// the update is applied when the request beat is taken; the store then reads
//   both ends in S_READ and the registered result beat is valid in S_OUT
// a new operation is not taken before the result beat of the last one is taken,
//   as the store's registered read of both ends follows the update
// one request is in flight at a time: req.ready stays low from acceptance
//   until the result beat is taken
// when the receiver stalls, the result beat holds steady and no new request
//   is taken
// reset (rst, synchronous) empties the queue, clears the reverse flag and
//   drops any pending result; the store contents are not cleared, no
//   clearing pass is needed
module reversible_deque
  import rdq_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input logic       clk,
  input logic       rst,
  rdq_req_if.sink   req,
  rdq_rsp_if.source rsp
);

  rdq_cmd_t cmd;

  rdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .rsp_ready (rsp.ready),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .cmd       (cmd)
  );

  rdq_datapath #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .op          (req.op),
    .push_value  (req.push_value),
    .front_value (rsp.front_value),
    .back_value  (rsp.back_value),
    .item_count  (rsp.item_count),
    .status      (rsp.status)
  );

endmodule

// File: sv/rdq_checker.sv
module rdq_checker
  import rdq_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      req_ready,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic signed [FIELD_W-1:0] front_value,
  input logic signed [FIELD_W-1:0] back_value,
  input logic [COUNT_W-1:0]        item_count,
  input logic [STATUS_W-1:0]       status
);

  // stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(front_value) &&
      $stable(back_value) && $stable(item_count) && $stable(status))
    else $error("stalled result beat changed");

  // no new request while a result is pending
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready)
    else $error("request taken while result pending");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_POP_EMPTY) |-> (item_count == '0))
    else $error("pop on empty flagged with items stored");

  a_empty_values: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_POP_EMPTY) |->
      (front_value == -32'sd1) && (back_value == -32'sd1))
    else $error("empty queue reports values other than -1");

endmodule

bind reversible_deque rdq_checker u_rdq_checker (
  .clk         (clk),
  .rst         (rst),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .front_value (rsp.front_value),
  .back_value  (rsp.back_value),
  .item_count  (rsp.item_count),
  .status      (rsp.status)
);
